// ===== rtl/tpmf_pkg.sv =====
// shared types and constants for the two-phase mobility face stencil
// no dependencies; used by every module of the block but the checker
package tpmf_pkg;

  localparam int unsigned ONE_Q15 = 32768;

  // operation codes of an input request
  localparam logic OP_PUSH  = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  // configuration register indexes
  localparam logic [2:0] REG_GRID_ROWS = 3'd0;
  localparam logic [2:0] REG_GRID_COLS = 3'd1;
  localparam logic [2:0] REG_INV_W     = 3'd2;
  localparam logic [2:0] REG_INV_N     = 3'd3;
  localparam logic [2:0] REG_EPS       = 3'd4;

  // face slots inside a job
  localparam logic [1:0] FACE_LEFT  = 2'd0;
  localparam logic [1:0] FACE_RIGHT = 2'd1;
  localparam logic [1:0] FACE_UP    = 2'd2;
  localparam logic [1:0] FACE_DOWN  = 2'd3;

  typedef struct packed {
    logic [10:0] grid_rows;
    logic [10:0] grid_cols;
    logic [15:0] inv_w;
    logic [15:0] inv_n;
    logic [15:0] eps;
  } cfg_t;

  // one result to compute: center value, four neighbours and border flags
  typedef struct packed {
    logic [9:0]         row;
    logic [9:0]         col;
    logic signed [31:0] center;
    logic signed [31:0] left;
    logic signed [31:0] right;
    logic signed [31:0] up;
    logic signed [31:0] down;
    logic [3:0]         has;
    logic               done;
  } job_t;

endpackage

// ===== rtl/tpmf_queue.sv =====
// two-entry job queue between the front and the back
// depends on tpmf_pkg for the job type
module tpmf_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  tpmf_pkg::job_t din,
  input  logic          pop,
  output tpmf_pkg::job_t dout,
  output logic          full,
  output logic          empty
);
  import tpmf_pkg::*;

  job_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign dout  = slots[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push && !full) wr_ptr <= ~wr_ptr;
      if (pop && !empty) rd_ptr <= ~rd_ptr;
      if ((push && !full) && !(pop && !empty)) count <= count + 2'd1;
      else if (!(push && !full) && (pop && !empty)) count <= count - 2'd1;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push && !full) slots[wr_ptr] <= din;
  end

endmodule

// ===== rtl/tpmf_front.sv =====
// front: accepts requests, computes the mobility difference, keeps the
// two line memory and the grid counters, and queues face jobs; uses tpmf_pkg
module tpmf_front #(
  parameter int MAX_COLS = 1024,
  parameter int MAX_ROWS = 1024
) (
  input  logic           clk,
  input  logic           rst,
  input  tpmf_pkg::cfg_t cfg,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic           operation,
  input  logic [15:0]    saturation,
  input  logic [15:0]    permeability,
  output logic           q_push,
  output tpmf_pkg::job_t q_din,
  input  logic           q_full
);
  import tpmf_pkg::*;

  localparam int CW = (MAX_COLS > 2) ? $clog2(MAX_COLS) : 1;
  localparam int RW = (MAX_ROWS > 2) ? $clog2(MAX_ROWS) : 1;
  localparam int AW = $clog2(2 * MAX_COLS);

  typedef enum logic [3:0] {
    F_IDLE, F_MUL1, F_MUL2, F_DIFF, F_RD0, F_RD1, F_RD2, F_RD3, F_RD4,
    F_WR, F_ENQ
  } fstate_t;

  fstate_t state;

  // grid counters
  logic [RW-1:0] input_row;
  logic [CW-1:0] input_col;
  logic [RW-1:0] output_row;
  logic [CW-1:0] output_col;
  logic          all_cells_in;

  // current request
  logic          op;
  logic          emit;
  logic [RW-1:0] o_row;
  logic [CW-1:0] o_col;
  logic [15:0]   sat_q;
  logic [15:0]   perm_q;

  // mobility datapath
  logic [30:0]        sq_w, sq_n;
  logic [31:0]        p_w, p_n;
  logic [31:0]        m_w, m_n;
  logic signed [31:0] d_val;
  logic [31:0]        kr_sum_w, kr_sum_n;
  logic [15:0]        kr_w, kr_n;
  logic [46:0]        prod_w, prod_n;
  logic signed [33:0] diff;

  // neighbourhood read back from the lines
  logic signed [31:0] ctr_q, left_q, right_q, up_q;

  // line memory
  logic [31:0]   lines [2*MAX_COLS];
  logic [AW-1:0] rd_addr;
  logic [31:0]   rd_data;

  logic [CW:0] cols_eff;
  logic [RW:0] rows_eff;
  logic [15:0] sat_clip;
  logic        ignore;
  logic        last_col;
  logic        last_row;

  // register values clamped to the usable range
  always_comb begin
    if (cfg.grid_cols < 11'd2) cols_eff = (CW+1)'(2);
    else if (32'(cfg.grid_cols) > MAX_COLS) cols_eff = (CW+1)'(MAX_COLS);
    else cols_eff = (CW+1)'(cfg.grid_cols);
    if (cfg.grid_rows < 11'd2) rows_eff = (RW+1)'(2);
    else if (32'(cfg.grid_rows) > MAX_ROWS) rows_eff = (RW+1)'(MAX_ROWS);
    else rows_eff = (RW+1)'(cfg.grid_rows);
  end

  function automatic logic [AW-1:0] line_addr(input logic line, input logic [CW-1:0] col);
    line_addr = line ? AW'(MAX_COLS + 32'(col)) : AW'(col);
  endfunction

  assign in_ready = (state == F_IDLE);
  assign ignore   = (operation == OP_PUSH) ? all_cells_in : !all_cells_in;
  assign sat_clip = (32'(saturation) > ONE_Q15) ? 16'(ONE_Q15) : saturation;
  assign last_col = ((CW+1)'(o_col) + (CW+1)'(1)) >= cols_eff;
  assign last_row = ((RW+1)'(input_row) + (RW+1)'(1)) >= rows_eff;

  // relative permeability rounding and mobility products
  assign kr_sum_w = 32'(sq_w) + 32'd16384;
  assign kr_sum_n = 32'(sq_n) + 32'd16384;
  assign kr_w     = kr_sum_w[30:15];
  assign kr_n     = kr_sum_n[30:15];
  assign prod_w   = p_w * kr_w;
  assign prod_n   = p_n * kr_n;
  assign diff     = $signed({2'b00, m_n}) - $signed({2'b00, m_w});

  // read address per read state
  always_comb begin
    case (state)
      F_RD0:   rd_addr = line_addr(o_row[0], o_col);
      F_RD1:   rd_addr = line_addr(o_row[0], o_col - CW'(1));
      F_RD2:   rd_addr = line_addr(o_row[0], o_col + CW'(1));
      F_RD3:   rd_addr = line_addr(~o_row[0], o_col);
      default: rd_addr = line_addr(o_row[0], o_col);
    endcase
  end

  // line memory ports
  always_ff @(posedge clk) begin
    rd_data <= lines[rd_addr];
    if (state == F_WR && op == OP_PUSH) lines[line_addr(input_row[0], o_col)] <= d_val;
  end

  // job handed to the back
  assign q_push = (state == F_ENQ) && emit && !q_full;
  always_comb begin
    q_din.row    = 10'(o_row);
    q_din.col    = 10'(o_col);
    q_din.center = ctr_q;
    q_din.left   = left_q;
    q_din.right  = right_q;
    q_din.up     = up_q;
    q_din.down   = d_val;
    q_din.has    = {op == OP_PUSH, o_row != '0, !last_col, o_col != '0};
    q_din.done   = (op == OP_DRAIN) && last_col;
  end

  // sequencer, counters and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= F_IDLE;
      input_row    <= '0;
      input_col    <= '0;
      output_row   <= '0;
      output_col   <= '0;
      all_cells_in <= 1'b0;
    end else begin
      case (state)
        F_IDLE: begin
          if (in_valid && !ignore) begin
            op     <= operation;
            sat_q  <= sat_clip;
            perm_q <= permeability;
            if (operation == OP_PUSH) begin
              emit  <= input_row != '0;
              o_row <= input_row - RW'(1);
              o_col <= input_col;
              state <= F_MUL1;
            end else begin
              emit  <= 1'b1;
              o_row <= output_row;
              o_col <= output_col;
              state <= F_RD0;
            end
          end
        end
        F_MUL1: begin
          sq_w  <= sat_q * sat_q;
          sq_n  <= (16'(ONE_Q15) - sat_q) * (16'(ONE_Q15) - sat_q);
          p_w   <= perm_q * cfg.inv_w;
          p_n   <= perm_q * cfg.inv_n;
          state <= F_MUL2;
        end
        F_MUL2: begin
          m_w   <= prod_w[46:15];
          m_n   <= prod_n[46:15];
          state <= F_DIFF;
        end
        F_DIFF: begin
          if (diff > 34'sh07FFFFFFF) d_val <= 32'sh7FFFFFFF;
          else if (diff < -34'sh080000000) d_val <= 32'sh80000000;
          else d_val <= diff[31:0];
          state <= F_RD0;
        end
        F_RD0: state <= F_RD1;
        F_RD1: begin
          ctr_q <= rd_data;
          state <= F_RD2;
        end
        F_RD2: begin
          left_q <= rd_data;
          state  <= F_RD3;
        end
        F_RD3: begin
          right_q <= rd_data;
          state   <= F_RD4;
        end
        F_RD4: begin
          up_q  <= rd_data;
          state <= F_WR;
        end
        F_WR: state <= F_ENQ;
        F_ENQ: begin
          if (!emit || !q_full) begin
            state <= F_IDLE;
            if (op == OP_PUSH) begin
              if (last_col) begin
                input_col <= '0;
                if (last_row) begin
                  all_cells_in <= 1'b1;
                  output_row   <= input_row;
                  output_col   <= '0;
                end else begin
                  input_row <= input_row + RW'(1);
                end
              end else begin
                input_col <= input_col + CW'(1);
              end
            end else if (last_col) begin
              input_row    <= '0;
              input_col    <= '0;
              output_row   <= '0;
              output_col   <= '0;
              all_cells_in <= 1'b0;
            end else begin
              output_col <= output_col + CW'(1);
            end
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/tpmf_back.sv =====
// back: computes the four faces of a job with one shared bit-serial divider
// and holds the result for the output channel; uses tpmf_pkg
module tpmf_back (
  input  logic               clk,
  input  logic               rst,
  input  logic [15:0]        eps,
  input  logic               q_empty,
  input  tpmf_pkg::job_t     q_dout,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [9:0]         cell_row,
  output logic [9:0]         cell_col,
  output logic signed [31:0] face_left,
  output logic signed [31:0] face_right,
  output logic signed [31:0] face_up,
  output logic signed [31:0] face_down,
  output logic               zero_divisor,
  output logic               grid_done
);
  import tpmf_pkg::*;

  typedef enum logic [2:0] {B_IDLE, B_MUL, B_PREP, B_DIV, B_OUT} bstate_t;

  bstate_t            state;
  job_t               job;
  logic [1:0]         fi;
  logic signed [31:0] faces [4];
  logic               zero_q;
  logic signed [63:0] num;
  logic signed [33:0] den;
  logic               neg;
  logic [63:0]        rem;
  logic [63:0]        dsh;
  logic [30:0]        quo;
  logic [4:0]         cnt;

  logic signed [31:0] nb;
  logic               has_face;
  logic signed [63:0] prod;
  logic [63:0]        num_mag;
  logic [63:0]        den_mag;
  logic               fits;
  logic [31:0]        q_fin;

  // neighbour of the current face
  always_comb begin
    case (fi)
      FACE_LEFT:  nb = job.left;
      FACE_RIGHT: nb = job.right;
      FACE_UP:    nb = job.up;
      default:    nb = job.down;
    endcase
  end

  assign has_face = job.has[fi];
  assign prod     = nb * job.center;
  assign num_mag  = num[63] ? 64'(-num) : 64'(num);
  assign den_mag  = den[33] ? 64'(-den) : 64'(den);
  assign fits     = num_mag < (den_mag << 31);
  assign q_fin    = neg ? -{1'b0, quo} : {1'b0, quo};

  assign q_pop        = (state == B_IDLE) && !q_empty;
  assign out_valid    = (state == B_OUT);
  assign cell_row     = job.row;
  assign cell_col     = job.col;
  assign face_left    = faces[FACE_LEFT];
  assign face_right   = faces[FACE_RIGHT];
  assign face_up      = faces[FACE_UP];
  assign face_down    = faces[FACE_DOWN];
  assign zero_divisor = zero_q;
  assign grid_done    = job.done;

  // face sequencer and restoring divider
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      case (state)
        B_IDLE: begin
          if (!q_empty) begin
            job    <= q_dout;
            fi     <= FACE_LEFT;
            zero_q <= 1'b0;
            state  <= B_MUL;
          end
        end
        B_MUL: begin
          if (has_face) begin
            num   <= prod;
            den   <= 34'(nb) + 34'(job.center) + 34'(eps);
            state <= B_PREP;
          end else begin
            faces[fi] <= '0;
            if (fi == FACE_DOWN) state <= B_OUT;
            fi <= fi + 2'd1;
          end
        end
        B_PREP: begin
          neg <= num[63] ^ den[33];
          if (den == '0) begin
            zero_q    <= 1'b1;
            faces[fi] <= '0;
            fi        <= fi + 2'd1;
            state     <= (fi == FACE_DOWN) ? B_OUT : B_MUL;
          end else if (!fits) begin
            faces[fi] <= (num[63] ^ den[33]) ? 32'sh80000000 : 32'sh7FFFFFFF;
            fi        <= fi + 2'd1;
            state     <= (fi == FACE_DOWN) ? B_OUT : B_MUL;
          end else begin
            rem   <= num_mag;
            dsh   <= den_mag << 30;
            quo   <= '0;
            cnt   <= 5'd30;
            state <= B_DIV;
          end
        end
        B_DIV: begin
          if (cnt == 5'd31) begin
            // close a division in the cycle after its last bit
            faces[fi] <= q_fin;
            fi        <= fi + 2'd1;
            state     <= (fi == FACE_DOWN) ? B_OUT : B_MUL;
          end else begin
            // one quotient bit per cycle, most significant first
            if (rem >= dsh) begin
              rem <= rem - dsh;
              quo <= {quo[29:0], 1'b1};
            end else begin
              quo <= {quo[29:0], 1'b0};
            end
            dsh <= dsh >> 1;
            cnt <= cnt - 5'd1;
          end
        end
        B_OUT: begin
          if (out_ready) state <= B_IDLE;
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/two_phase_mobility_face_stencil_core.sv =====
// Two-phase mobility face stencil. Cells enter in raster order; the front
// sequencer runs the mobility multiplies, four line memory reads, one write
// and the hand-off on a push, and skips the multiplies and write on a drain.
// The back pops each job and then, per face, runs a setup, a single divider
// that yields one quotient bit per cycle and a closing step, and then holds
// the result on the output while the output stalls. A two-entry job
// queue lets the front keep accepting while a result waits on the output.
// Results run one row behind the input; drain requests flush the final row.
// top level: configuration registers, front, job queue and back; uses tpmf_pkg
module two_phase_mobility_face_stencil_core #(
  parameter int MAX_COLS = 1024,
  parameter int MAX_ROWS = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_addr,
  input  logic [15:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               operation,
  input  logic [15:0]        saturation,
  input  logic [15:0]        permeability,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [9:0]         cell_row,
  output logic [9:0]         cell_col,
  output logic signed [31:0] face_left,
  output logic signed [31:0] face_right,
  output logic signed [31:0] face_up,
  output logic signed [31:0] face_down,
  output logic               zero_divisor,
  output logic               grid_done
);
  import tpmf_pkg::*;

  cfg_t cfg;
  logic q_push, q_pop, q_full, q_empty;
  job_t q_din, q_dout;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.grid_rows <= 11'd64;
      cfg.grid_cols <= 11'd64;
      cfg.inv_w     <= 16'd256;
      cfg.inv_n     <= 16'd256;
      cfg.eps       <= 16'd1;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_GRID_ROWS: cfg.grid_rows <= cfg_wdata[10:0];
        REG_GRID_COLS: cfg.grid_cols <= cfg_wdata[10:0];
        REG_INV_W:     cfg.inv_w     <= cfg_wdata;
        REG_INV_N:     cfg.inv_n     <= cfg_wdata;
        REG_EPS:       cfg.eps       <= cfg_wdata;
        default:       ;
      endcase
    end
  end

  tpmf_front #(.MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS)) u_front (
    .clk, .rst, .cfg, .in_valid, .in_ready, .operation, .saturation,
    .permeability, .q_push, .q_din, .q_full
  );

  tpmf_queue u_queue (
    .clk, .rst, .push(q_push), .din(q_din), .pop(q_pop), .dout(q_dout),
    .full(q_full), .empty(q_empty)
  );

  tpmf_back u_back (
    .clk, .rst, .eps(cfg.eps), .q_empty, .q_dout, .q_pop, .out_valid,
    .out_ready, .cell_row, .cell_col, .face_left, .face_right, .face_up,
    .face_down, .zero_divisor, .grid_done
  );

endmodule

// ===== rtl/tpmf_checker.sv =====
// port-level checks for the face stencil core, bound to the top level
// depends only on the top level's ports
module tpmf_checker (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_ready,
  input logic [9:0]         cell_col,
  input logic signed [31:0] face_left,
  input logic signed [31:0] face_right,
  input logic signed [31:0] face_down,
  input logic               grid_done
);

  // a stalled result stays valid and holds its left face and column
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(face_left) && $stable(cell_col))
    else $error("stalled result changed");

  // no result right after reset
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // final cell sits on the right border of the last row
  a_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && grid_done |-> face_right == '0 && face_down == '0)
    else $error("final cell has a right or lower face");

  // first column has no left face
  a_left: assert property (@(posedge clk) disable iff (rst)
    out_valid && cell_col == '0 |-> face_left == '0)
    else $error("left border face not zero");

endmodule

bind two_phase_mobility_face_stencil_core tpmf_checker u_checker (
  .clk, .rst, .out_valid, .out_ready, .cell_col, .face_left, .face_right,
  .face_down, .grid_done
);
